// ===== sv/thcv_pkg.sv =====
// Package for the trailing hex checksum validator.
// Holds the item types, register indexes, character constants and the hex digit decoder.
// No dependencies.
`default_nettype none

package thcv_pkg;

  localparam int unsigned MAX_MESSAGE_LENGTH_DEFAULT = 255;

  localparam int unsigned WINDOW_DEPTH = 6;
  localparam int unsigned HEX_DIGITS   = 4;

  localparam logic [7:0] MARKER_RESET = 8'd35;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] DIGIT_TEN    = 8'd10;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_ALLOW_NO_CHECKSUM = 1'b0;
  localparam cfg_index_t REG_MARKER_CHAR       = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       checksum_present;
    logic [7:0] payload_length;
    logic       too_long;
  } out_item_t;

  // Trailer status handed from the trailer checker to the core
  typedef struct packed {
    logic framed;
    logic matched;
  } trailer_t;

  // Bit 4 set means the character is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
      d = c - CHAR_ZERO;
      return {1'b0, d[3:0]};
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5) begin
      d = c - CHAR_UPPER_A + DIGIT_TEN;
      return {1'b0, d[3:0]};
    end
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5) begin
      d = c - CHAR_LOWER_A + DIGIT_TEN;
      return {1'b0, d[3:0]};
    end
    return 5'b1_0000;
  endfunction

endpackage

`default_nettype wire

// ===== sv/thcv_trailer_check.sv =====
// Trailer checker: marker framing and hex value compare against the running sum.
// Depends on thcv_pkg.
`default_nettype none

module thcv_trailer_check (
  input  wire logic [7:0]         marker,
  input  wire logic [7:0]         open_char,
  input  wire logic [7:0]         close_char,
  input  wire logic [4*8-1:0]     digits,
  input  wire logic [15:0]        sum,
  output thcv_pkg::trailer_t      status
);
  import thcv_pkg::*;

  logic [4:0]  dig [HEX_DIGITS];
  logic        any_bad;
  logic [15:0] value;

  always_comb begin
    any_bad = 1'b0;
    for (int i = 0; i < HEX_DIGITS; i++) begin
      // most significant digit sits in the upper byte
      dig[i]  = hex_digit(digits[(HEX_DIGITS-1-i)*8 +: 8]);
      any_bad = any_bad | dig[i][4];
    end
    value = any_bad ? 16'd0 : {dig[0][3:0], dig[1][3:0], dig[2][3:0], dig[3][3:0]};
    status.framed  = (open_char == marker) && (close_char == marker);
    status.matched = (value == sum);
  end

endmodule

`default_nettype wire

// ===== sv/thcv_core.sv =====
// Message state: tail window, running sum, byte count and overflow flag.
// Computes the result of a final byte. Depends on thcv_pkg and thcv_trailer_check.
`default_nettype none

module thcv_core #(
  parameter int unsigned MAX_MESSAGE_LENGTH = thcv_pkg::MAX_MESSAGE_LENGTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire thcv_pkg::in_item_t  item,
  input  wire logic                allow_no_checksum,
  input  wire logic [7:0]          marker_char,
  output thcv_pkg::out_item_t      result
);
  import thcv_pkg::*;

  localparam int unsigned CW = $clog2(MAX_MESSAGE_LENGTH + 1);
  localparam int unsigned LW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_MESSAGE_LENGTH);
  localparam logic [CW-1:0] COUNT_WIN = CW'(WINDOW_DEPTH);

  logic [7:0]    window [WINDOW_DEPTH];
  logic [15:0]   running_sum;
  logic [CW-1:0] byte_count;
  logic          overflowed;

  logic [15:0]   sum_next;
  logic [CW-1:0] count_next;
  logic          ovf_next;
  logic [LW-1:0] len_full;
  logic [LW-1:0] len_strip;
  trailer_t      trailer;

  always_comb begin
    sum_next   = (byte_count >= COUNT_WIN) ? 16'(running_sum + {8'd0, window[0]}) : running_sum;
    count_next = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;
    ovf_next   = overflowed | (byte_count >= COUNT_MAX);
    len_full   = LW'(count_next);
    len_strip  = len_full - LW'(WINDOW_DEPTH);
  end

  // After the shift the window holds window[1..5] and the new byte
  thcv_trailer_check u_trailer (
    .marker     (marker_char),
    .open_char  (window[1]),
    .close_char (item.data_byte),
    .digits     ({window[2], window[3], window[4], window[5]}),
    .sum        (sum_next),
    .status     (trailer)
  );

  always_comb begin
    result = '0;
    if (ovf_next) begin
      result.too_long = 1'b1;
    end else if (count_next >= COUNT_WIN && trailer.framed) begin
      result.checksum_present = 1'b1;
      result.accepted         = trailer.matched;
      result.payload_length   = trailer.matched ? len_strip[7:0] : len_full[7:0];
    end else begin
      result.accepted       = allow_no_checksum;
      result.payload_length = len_full[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) window[i] <= 8'd0;
      running_sum <= 16'd0;
      byte_count  <= '0;
      overflowed  <= 1'b0;
    end else if (step) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) window[i] <= window[i+1];
      window[WINDOW_DEPTH-1] <= item.data_byte;
      running_sum <= sum_next;
      byte_count  <= count_next;
      overflowed  <= ovf_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> byte_count == '0 && running_sum == 16'd0 && !overflowed)
    else $error("state not cleared after final byte");

  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> byte_count == COUNT_MAX)
    else $error("overflow flag set below the length limit");

  a_sum_idle_short: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_WIN |-> running_sum == 16'd0)
    else $error("sum grew before any byte left the window");

endmodule

`default_nettype wire

// ===== sv/trailing_hex_checksum_validator_unit.sv =====
// Trailing hex checksum validator, top level.
// Message bytes enter on the item channel (valid/stall), one byte per transfer, with
// last_byte set on the final byte. Each message ending in marker, four hex digits,
// marker is checked against the 16-bit wrapping sum of the bytes before the trailer.
// One result transfer leaves on the result channel for every final byte; other bytes
// produce none.
// A byte taken into the input register is processed there; a final byte's result is
// then registered in the result register. Throughput: one byte per cycle, set by the
// single add-and-compare step between the two registers, unless a final byte stalls.
// A result waiting under stall does not block the input: the input register keeps
// taking bytes that are not final; a final byte waits there, with item_stall high,
// until the result register frees up.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 = allow_no_checksum, 1 = marker
// character; cfg_ready is always high. Write only while no message is in flight.
// Reset (rst, synchronous): clears the message state and both valid flags, sets
// allow_no_checksum to 0 and the marker to '#'. The block is ready the next cycle.
// Depends on thcv_pkg and thcv_core.
`default_nettype none

module trailing_hex_checksum_validator_unit #(
  parameter int unsigned MAX_MESSAGE_LENGTH = thcv_pkg::MAX_MESSAGE_LENGTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire thcv_pkg::in_item_t   item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output thcv_pkg::out_item_t       result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire thcv_pkg::cfg_index_t cfg_index,
  input  wire logic [7:0]           cfg_data
);
  import thcv_pkg::*;

  logic       allow_no_checksum;
  logic [7:0] marker_char;

  logic      hold_valid;
  in_item_t  hold;
  logic      out_free;
  logic      advance;
  out_item_t core_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_no_checksum <= 1'b0;
      marker_char       <= MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALLOW_NO_CHECKSUM: allow_no_checksum <= cfg_data[0];
        REG_MARKER_CHAR:       marker_char       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process the held byte unless it is final and the result register is still full
  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && (!hold.last_byte || out_free);
  assign item_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      hold <= item;
    end
  end

  thcv_core #(
    .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .item              (hold),
    .allow_no_checksum (allow_no_checksum),
    .marker_char       (marker_char),
    .result            (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && hold.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && hold.last_byte) begin
      result <= core_result;
    end
  end

  a_too_long_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_long |->
      !result.accepted && !result.checksum_present && result.payload_length == 8'd0)
    else $error("too_long result carries other flags");

  a_no_trailer_policy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.too_long && !result.checksum_present |->
      result.accepted == allow_no_checksum)
    else $error("message without trailer ignores allow_no_checksum");

  a_final_waits: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && hold.last_byte)
    else $error("held final byte lost while result register was full");

endmodule

`default_nettype wire
